// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, disabled while reset is asserted.
`define MDCI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MDCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`MDCI_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ----- rtl/mdci_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modulated delay package
// Sizes, types and helpers shared by the modulated delay line files.
// ----------------------------------------------------------------------------
package mdci_pkg;

	localparam int DELAY_CAPACITY = 1024;
	localparam int FRACTION_BITS  = 8;

	localparam int SAMPLE_W = 16;
	localparam int MOD_W    = 16;
	localparam int DEPTH_W  = 18;
	localparam int FACTOR_W = 17;

	localparam int PTR_W  = $clog2(DELAY_CAPACITY);
	localparam int FILL_W = PTR_W + 1;
	localparam int RPOS_W = PTR_W + FRACTION_BITS;

	// Delay before its final clamp: below 2^18 * 2^17 / 2^16.
	localparam int DLY_RAW_W = 19;
	localparam int CMP_W     = ((RPOS_W > DLY_RAW_W) ? RPOS_W : DLY_RAW_W) + 2;

	// The interpolation accumulator stays below 2^20 in magnitude.
	localparam int ACC_W  = 22;
	localparam int MULA_W = 22;
	localparam int MULB_W = 18;
	localparam int PROD_W = MULA_W + MULB_W;

	localparam logic [CMP_W-1:0] DELAY_LIMIT =
		CMP_W'(longint'(DELAY_CAPACITY - 2) << FRACTION_BITS);
	localparam logic [CMP_W-1:0] SPAN =
		CMP_W'(longint'(DELAY_CAPACITY) << FRACTION_BITS);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MOD_W-1:0]    mod_t;
	typedef logic [PTR_W-1:0]           ptr_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	function automatic ptr_t wrap_next(input ptr_t i);
		logic [FILL_W-1:0] n;
		n = {1'b0, i} + FILL_W'(1);
		return (n >= FILL_W'(DELAY_CAPACITY)) ? '0 : n[PTR_W-1:0];
	endfunction

endpackage

// ----- rtl/mdci_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one audio sample and one modulator value.
// ----------------------------------------------------------------------------
interface mdci_in_if;
	import mdci_pkg::*;

	logic    valid;
	logic    ready;
	sample_t input_sample;
	mod_t    modulator_value;

	modport source (output valid, output input_sample, output modulator_value, input ready);
	modport sink (input valid, input input_sample, input modulator_value, output ready);
endinterface

// ----- rtl/mdci_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one interpolated delayed sample.
// ----------------------------------------------------------------------------
interface mdci_out_if;
	import mdci_pkg::*;

	logic    valid;
	logic    ready;
	sample_t output_sample;

	modport source (output valid, output output_sample, input ready);
	modport sink (input valid, input output_sample, output ready);
endinterface

// ----- rtl/modulated_delay_cubic_interp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modulated delay line with cubic interpolation
// The sequencer runs the single multiplier four times and reads four neighbors
// from the one read port; a new item is accepted only while it is idle, after
// the last result has been loaded into the output register.
// Reset clears the depth register, write pointer and fill count at once; the
// store needs no clearing pass, since entries not yet written read as zero.
// ----------------------------------------------------------------------------
module modulated_delay_cubic_interp_top (
	input  logic                          clk,
	input  logic                          arst_n,
	mdci_in_if.sink                       din,
	mdci_out_if.source                    dout,
	input  logic                          depth_we,
	input  logic [mdci_pkg::DEPTH_W-1:0]  depth_wdata
);
	import mdci_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DLY  = 4'd1;
	localparam logic [3:0] S_ADR  = 4'd2;
	localparam logic [3:0] S_RD0  = 4'd3;
	localparam logic [3:0] S_RD1  = 4'd4;
	localparam logic [3:0] S_RD2  = 4'd5;
	localparam logic [3:0] S_RD3  = 4'd6;
	localparam logic [3:0] S_COEF = 4'd7;
	localparam logic [3:0] S_H1   = 4'd8;
	localparam logic [3:0] S_H2   = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	localparam acc_t SAT_MAX = ACC_W'(32767);
	localparam acc_t SAT_MIN = -ACC_W'(32768);

	function automatic acc_t sx(input sample_t v);
		return ACC_W'(v);
	endfunction

	logic [3:0]              state_q;
	logic [DEPTH_W-1:0]      depth_q;
	ptr_t                    wp_q;
	logic [FILL_W-1:0]       fill_q;
	logic                    out_valid_q;
	sample_t                 out_q;

	sample_t                 sample_q;
	logic [FACTOR_W-1:0]     factor_q;
	logic [RPOS_W-1:0]       delay_q;
	logic [FRACTION_BITS-1:0] frac_q;
	ptr_t                    rd_idx_q;
	sample_t                 v0_q, v1_q, v2_q;
	acc_t                    acc_q, b_q, c_q;

	sample_t                 mem [DELAY_CAPACITY];
	sample_t                 rd_data_q;
	logic                    rd_ok_q;

	logic [CMP_W-1:0]        depth_c;
	logic [FACTOR_W-1:0]     factor;
	logic signed [MULA_W-1:0] mul_a;
	logic signed [MULB_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [DLY_RAW_W-1:0]    dly_raw;
	logic [CMP_W-1:0]        dly_c;
	logic [CMP_W-1:0]        diff;
	logic [CMP_W-1:0]        rpos;
	ptr_t                    i1;
	sample_t                 rd_val;
	acc_t                    coef_a, coef_b, coef_c;
	acc_t                    t_shr;
	acc_t                    res;
	sample_t                 res_sat;
	logic                    mem_we;
	logic                    out_load;

	assign depth_c = (CMP_W'(depth_q) > DELAY_LIMIT) ? DELAY_LIMIT : CMP_W'(depth_q);
	// One plus half the modulator, in Q16.
	assign factor  = FACTOR_W'(32'sd65536 + 32'(din.modulator_value));

	// The one shared multiplier: delay scaling first, then the Horner steps.
	always_comb begin
		if (state_q == S_DLY) begin
			mul_a = MULA_W'(depth_c);
			mul_b = MULB_W'({1'b0, factor_q});
		end else begin
			mul_a = MULA_W'(acc_q);
			mul_b = MULB_W'({1'b0, frac_q});
		end
	end
	assign mul_p = mul_a * mul_b;

	assign dly_raw = mul_p[16 +: DLY_RAW_W];
	assign dly_c   = (CMP_W'(dly_raw) > DELAY_LIMIT) ? DELAY_LIMIT : CMP_W'(dly_raw);

	assign diff = CMP_W'({wp_q, {FRACTION_BITS{1'b0}}}) - CMP_W'(delay_q);
	assign rpos = diff[CMP_W-1] ? diff + SPAN : diff;
	assign i1   = rpos[RPOS_W-1:FRACTION_BITS];

	// Entries beyond the fill count were never written and read as zero.
	assign rd_val = rd_ok_q ? rd_data_q : '0;

	assign coef_a = ACC_W'(-sx(v0_q) + 3 * sx(v1_q) - 3 * sx(v2_q) + sx(rd_val));
	assign coef_b = ACC_W'(2 * sx(v0_q) - 5 * sx(v1_q) + 4 * sx(v2_q) - sx(rd_val));
	assign coef_c = ACC_W'(sx(v2_q) - sx(v0_q));

	assign t_shr = ACC_W'(mul_p >>> FRACTION_BITS);
	assign res   = (t_shr >>> 1) + sx(v1_q);
	always_comb begin
		if (res > SAT_MAX) begin
			res_sat = SAMPLE_W'(SAT_MAX);
		end else if (res < SAT_MIN) begin
			res_sat = SAMPLE_W'(SAT_MIN);
		end else begin
			res_sat = SAMPLE_W'(res);
		end
	end

	assign mem_we   = (state_q == S_COEF);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || dout.ready);

	assign din.ready          = (state_q == S_IDLE);
	assign dout.valid         = out_valid_q;
	assign dout.output_sample = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= sample_q;
		end
		rd_data_q <= mem[rd_idx_q];
		rd_ok_q   <= (FILL_W'(rd_idx_q) < fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (depth_we) begin
				depth_q <= depth_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (din.valid) begin
						state_q <= S_DLY;
					end
				end
				S_DLY:  state_q <= S_ADR;
				S_ADR:  state_q <= S_RD0;
				S_RD0:  state_q <= S_RD1;
				S_RD1:  state_q <= S_RD2;
				S_RD2:  state_q <= S_RD3;
				S_RD3:  state_q <= S_COEF;
				S_COEF: begin
					wp_q <= wrap_next(wp_q);
					if (fill_q != FILL_W'(DELAY_CAPACITY)) begin
						fill_q <= fill_q + FILL_W'(1);
					end
					state_q <= S_H1;
				end
				S_H1:   state_q <= S_H2;
				S_H2:   state_q <= S_FIN;
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			sample_q <= din.input_sample;
			factor_q <= factor;
		end
		if (state_q == S_DLY) begin
			delay_q <= dly_c[RPOS_W-1:0];
		end
		if (state_q == S_ADR) begin
			frac_q   <= rpos[FRACTION_BITS-1:0];
			rd_idx_q <= (i1 == '0) ? PTR_W'(DELAY_CAPACITY - 1) : i1 - PTR_W'(1);
		end
		if (state_q == S_RD0 || state_q == S_RD1 || state_q == S_RD2 || state_q == S_RD3) begin
			rd_idx_q <= wrap_next(rd_idx_q);
		end
		if (state_q == S_RD1) begin
			v0_q <= rd_val;
		end
		if (state_q == S_RD2) begin
			v1_q <= rd_val;
		end
		if (state_q == S_RD3) begin
			v2_q <= rd_val;
		end
		if (state_q == S_COEF) begin
			acc_q <= coef_a;
			b_q   <= coef_b;
			c_q   <= coef_c;
		end
		if (state_q == S_H1) begin
			acc_q <= t_shr + b_q;
		end
		if (state_q == S_H2) begin
			acc_q <= t_shr + c_q;
		end
		if (out_load) begin
			out_q <= res_sat;
		end
	end

endmodule

// ----- rtl/mdci_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modulated delay checker
// Port-level assertions on the handshakes of the modulated delay line.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdci_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [mdci_pkg::SAMPLE_W-1:0]  output_sample
);
	import mdci_pkg::*;

	// An accepted item keeps the block busy for the following cycle.
	`MDCI_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input ready after accept")

	// A new result only appears at the end of an item's work.
	`MDCI_ASSERT(a_result_from_work, clk, arst_n, $rose(out_valid) |-> $past(!in_ready), "result without an item in work")

	// A stalled result holds its value.
	`MDCI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(output_sample), "stalled result changed")

endmodule

bind modulated_delay_cubic_interp_top mdci_checker u_mdci_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (din.valid),
	.in_ready      (din.ready),
	.out_valid     (dout.valid),
	.out_ready     (dout.ready),
	.output_sample (dout.output_sample)
);
